FILE: hdl/scs_pkg.sv
// scs_pkg: shared types, command codes and the half-step coil table
// for the calibrating stepper sequencer; no dependencies
package scs_pkg;

  // field widths of the item and result words
  localparam int CMD_BITS     = 2;
  localparam int EIGHTHS_BITS = 10;
  localparam int SPR_BITS     = 16;
  localparam int PROD_BITS    = EIGHTHS_BITS + SPR_BITS;
  // run length is eighths * spr / 8, so three bits fall away
  localparam int REM_BITS     = PROD_BITS - 3;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RUN  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CAL  = 2'd2;

  // nominal steps per revolution after reset
  localparam logic [SPR_BITS-1:0] NOMINAL_SPR_RST = 16'd4096;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_RUN,
    MODE_SEEK,
    MODE_LOW,
    MODE_HIGH
  } mode_t;

  // one input word as held in the input register
  typedef struct packed {
    logic [CMD_BITS-1:0]     command;
    logic [EIGHTHS_BITS-1:0] eighths;
    logic                    opto_level;
  } scs_item_t;

  // eight-phase half-step drive pattern
  function automatic logic [3:0] half_step_coils(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/scs_ifs.sv
// scs_ifs: valid/ready channel interfaces for the item, result and
// configuration words of the stepper sequencer; no dependencies

// input word channel
interface scs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [9:0] eighths;
  logic       opto_level;
  modport source (output valid, command, eighths, opto_level, input ready);
  modport sink   (input valid, command, eighths, opto_level, output ready);
endinterface

// result word channel
interface scs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coils;
  logic        stepped;
  logic        busy_res;
  logic        calibrated;
  logic [15:0] measured_steps;
  logic        rejected;
  modport source (output valid, coils, stepped, busy_res, calibrated, measured_steps,
                  rejected, input ready);
  modport sink   (input valid, coils, stepped, busy_res, calibrated, measured_steps,
                  rejected, output ready);
endinterface

// configuration write channel, one register
interface scs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/scs_in_stage.sv
// scs_in_stage: input register for the command word
// depends on scs_pkg and scs_in_if
module scs_in_stage import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  scs_in_if.sink     in_ch,
  input  logic       take,
  output logic       item_valid,
  output scs_item_t  item
);

  logic      valid_r;
  scs_item_t item_r;

  // free when empty or when the held word moves on this cycle
  assign in_ch.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // payload capture, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.command    <= in_ch.command;
      item_r.eighths    <= in_ch.eighths;
      item_r.opto_level <= in_ch.opto_level;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hdl/scs_ceil_div.sv
// scs_ceil_div: ceiling of a lap total over the lap count by reciprocal
// multiply, saturated to 16 bits; no dependencies
module scs_ceil_div #(
  parameter int DIVISOR = 3,
  parameter int IN_BITS = 18
) (
  input  logic [IN_BITS-1:0] total,
  output logic [15:0]        quot
);

  // x = total + DIVISOR - 1 fits in X_BITS; shift S keeps the quotient exact
  localparam int X_BITS = IN_BITS + 1;
  localparam int S      = X_BITS + 2;
  localparam int M_BITS = S + 1;
  localparam int P_BITS = X_BITS + M_BITS;
  localparam int Q_BITS = P_BITS - S;
  localparam longint unsigned MULT_L =
    ((64'd1 << S) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
  localparam logic [M_BITS-1:0] MULT = MULT_L[M_BITS-1:0];
  localparam logic [Q_BITS-1:0] Q_MAX = Q_BITS'(16'hFFFF);

  logic [X_BITS-1:0] x;
  logic [P_BITS-1:0] prod;
  logic [Q_BITS-1:0] q;

  // round up, then multiply by the scaled reciprocal
  assign x    = {1'b0, total} + X_BITS'(DIVISOR - 1);
  assign prod = P_BITS'(x) * P_BITS'(MULT);
  assign q    = prod[P_BITS-1:S];

  // saturate to the result width
  assign quot = (q > Q_MAX) ? 16'hFFFF : q[15:0];

endmodule

FILE: hdl/scs_engine.sv
// scs_engine: sequencer state, next-state logic and result register
// depends on scs_pkg, scs_ceil_div, scs_out_if and scs_cfg_if
module scs_engine import scs_pkg::*; #(
  parameter int CAL_LAPS   = 3,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  scs_item_t  item,
  output logic       take,
  scs_out_if.source  out_ch,
  scs_cfg_if.sink    cfg_ch
);

  localparam int TOT_BITS = COUNT_BITS + 2;
  localparam logic [1:0] LAPS_LAST = 2'(CAL_LAPS);

  mode_t                 mode_r, mode_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [3:0]            coil_r, coil_nxt;
  logic [COUNT_BITS-1:0] lap_count_r, lap_count_nxt, count_base;
  logic [TOT_BITS-1:0]   lap_total_r, lap_total_nxt, tot_sat;
  logic [TOT_BITS:0]     tot_sum;
  logic [1:0]            laps_done_r, laps_done_nxt, laps_inc;
  logic [SPR_BITS-1:0]   spr_r, spr_nxt, div_q, spr_sel;
  logic                  cal_r, cal_nxt;
  logic [REM_BITS-1:0]   rem_r, rem_nxt;
  logic [SPR_BITS-1:0]   nominal_r;
  logic [PROD_BITS-1:0]  run_prod;
  logic                  do_step, do_count, count_clr, stepped, rejected, busy;

  logic                  out_valid_r;
  logic [3:0]            out_coils_r;
  logic                  out_stepped_r, out_busy_r, out_cal_r, out_rej_r;
  logic [SPR_BITS-1:0]   out_spr_r;

  // a held word is processed when the result register can take it
  assign take = item_valid && (!out_valid_r || out_ch.ready);

  // configuration register, always writable
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= NOMINAL_SPR_RST;
    end else if (cfg_ch.valid) begin
      nominal_r <= cfg_ch.data;
    end
  end

  // lap end: saturating accumulate and the averaged result
  assign tot_sum  = {1'b0, lap_total_r} + (TOT_BITS + 1)'(lap_count_r);
  assign tot_sat  = tot_sum[TOT_BITS] ? {TOT_BITS{1'b1}} : tot_sum[TOT_BITS-1:0];
  assign laps_inc = laps_done_r + 2'd1;

  scs_ceil_div #(
    .DIVISOR (CAL_LAPS),
    .IN_BITS (TOT_BITS)
  ) u_div (
    .total (tot_sat),
    .quot  (div_q)
  );

  // run length
  assign spr_sel  = cal_r ? spr_r : nominal_r;
  assign run_prod = PROD_BITS'(item.eighths) * PROD_BITS'(spr_sel);
  assign busy     = (mode_r != MODE_IDLE);

  // next state
  always_comb begin
    mode_nxt      = mode_r;
    rem_nxt       = rem_r;
    lap_total_nxt = lap_total_r;
    laps_done_nxt = laps_done_r;
    spr_nxt       = spr_r;
    cal_nxt       = cal_r;
    lap_count_nxt = lap_count_r;
    do_step       = 1'b0;
    do_count      = 1'b0;
    count_clr     = 1'b0;
    stepped       = 1'b0;
    rejected      = 1'b0;

    unique case (item.command)
      CMD_TICK: begin
        unique case (mode_r)
          MODE_IDLE: begin
          end
          MODE_RUN: begin
            if (rem_r != '0) begin
              do_step = 1'b1;
              rem_nxt = rem_r - 1'b1;
              if (rem_r == REM_BITS'(1)) begin
                mode_nxt = MODE_IDLE;
              end
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_SEEK: begin
            if (item.opto_level) begin
              do_step = 1'b1;
            end else begin
              mode_nxt  = MODE_LOW;
              count_clr = 1'b1;
              do_count  = 1'b1;
            end
          end
          MODE_LOW: begin
            if (item.opto_level) begin
              mode_nxt = MODE_HIGH;
            end
            do_count = 1'b1;
          end
          MODE_HIGH: begin
            if (item.opto_level) begin
              do_count = 1'b1;
            end else begin
              // lap ends on the falling level
              lap_total_nxt = tot_sat;
              laps_done_nxt = laps_inc;
              if (laps_inc >= LAPS_LAST) begin
                spr_nxt  = div_q;
                cal_nxt  = 1'b1;
                mode_nxt = MODE_IDLE;
              end else begin
                mode_nxt  = MODE_LOW;
                count_clr = 1'b1;
                do_count  = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_RUN: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          rem_nxt = run_prod[PROD_BITS-1:3];
          if (run_prod[PROD_BITS-1:3] != '0) begin
            mode_nxt = MODE_RUN;
          end
        end
      end
      CMD_CAL: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          mode_nxt      = MODE_SEEK;
          lap_count_nxt = '0;
          lap_total_nxt = '0;
          laps_done_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    // saturating lap counter
    count_base = count_clr ? '0 : lap_count_r;
    if (do_count) begin
      do_step       = 1'b1;
      lap_count_nxt = (&count_base) ? count_base : count_base + 1'b1;
    end

    // half step
    stepped   = do_step;
    coil_nxt  = do_step ? half_step_coils(phase_r) : coil_r;
    phase_nxt = do_step ? phase_r + 3'd1 : phase_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      phase_r     <= '0;
      coil_r      <= '0;
      lap_count_r <= '0;
      lap_total_r <= '0;
      laps_done_r <= '0;
      spr_r       <= '0;
      cal_r       <= 1'b0;
      rem_r       <= '0;
    end else if (take) begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      coil_r      <= coil_nxt;
      lap_count_r <= lap_count_nxt;
      lap_total_r <= lap_total_nxt;
      laps_done_r <= laps_done_nxt;
      spr_r       <= spr_nxt;
      cal_r       <= cal_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_coils_r   <= coil_nxt;
      out_stepped_r <= stepped;
      out_busy_r    <= (mode_nxt != MODE_IDLE);
      out_cal_r     <= cal_nxt;
      out_spr_r     <= spr_nxt;
      out_rej_r     <= rejected;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.coils          = out_coils_r;
  assign out_ch.stepped        = out_stepped_r;
  assign out_ch.busy_res       = out_busy_r;
  assign out_ch.calibrated     = out_cal_r;
  assign out_ch.measured_steps = out_spr_r;
  assign out_ch.rejected       = out_rej_r;

  // coils always show the phase just left behind after a step
  a_step_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (take && do_step) |=> (coil_r == half_step_coils(phase_r - 3'd1)))
    else $error("coil latch out of step with phase");

  // a rejected command leaves the sequencer alone
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && rejected) |=> ($stable(mode_r) && $stable(rem_r) && $stable(laps_done_r)))
    else $error("rejected command changed state");

  // a run never sits with nothing left to do
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_RUN) |-> (rem_r != '0))
    else $error("run mode with zero steps left");

  // calibration never runs past its last lap
  a_lap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SEEK || mode_r == MODE_LOW || mode_r == MODE_HIGH)
      |-> (laps_done_r < LAPS_LAST))
    else $error("lap count past the last lap");

  // every processed word yields a result
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("processed word without a result");

endmodule

FILE: hdl/stepper_calibrating_sequencer_core.sv
// stepper_calibrating_sequencer_core: top level of the half-step stepper
// sequencer; depends on scs_pkg, scs_ifs, scs_in_stage and scs_engine
//
// Each word on in_ch is one command: tick (one step period), run (eighths
// of a revolution) or start calibration, any other code being ignored; each
// yields exactly one result word on out_ch. A word is held in the input
// register while the state update is worked out, and its result word is
// loaded into the result register and presented on out_ch from there. A new
// word is accepted every cycle as long as out_ch keeps taking results. The
// state update, including the run length multiply and the averaging of the
// calibration laps, is combinational. The nominal steps per revolution is
// written on cfg_ch, which is always ready, and should only be changed while
// no word is in flight. No clearing pass is needed after reset.
module stepper_calibrating_sequencer_core import scs_pkg::*; #(
  parameter int CAL_LAPS   = 3,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  scs_in_if.sink    in_ch,
  scs_out_if.source out_ch,
  scs_cfg_if.sink   cfg_ch
);

  logic      item_valid;
  logic      take;
  scs_item_t item;

  // input register
  scs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // sequencer state and result register
  scs_engine #(
    .CAL_LAPS   (CAL_LAPS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch)
  );

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking bench for the calibrating half-step stepper sequencer
// depends on scs_pkg, scs_ifs and stepper_calibrating_sequencer_core
// queued command words are driven in phases with random idling and checked against a shadow model
module tb_top;
  import scs_pkg::*;

  localparam int CAL_LAPS       = 3;
  localparam int COUNT_BITS     = 16;
  localparam int SUM_BITS       = COUNT_BITS + 3;
  localparam int RUN_BITS       = 26;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CMD_BITS-1:0]   CMD_IGNORED = 2'd3;
  localparam logic [COUNT_BITS-1:0] LAP_MAX     = '1;
  localparam logic [COUNT_BITS+1:0] TOTAL_MAX   = '1;
  // half-step drive pattern, phase 0 in the low nibble
  localparam logic [31:0] DRIVE_TABLE = 32'h98C46231;

  typedef struct packed {
    mode_t                   mode;
    logic [2:0]              phase;
    logic [3:0]              coils;
    logic [COUNT_BITS-1:0]   lap_count;
    logic [COUNT_BITS+1:0]   lap_total;
    logic [1:0]              laps_done;
    logic [SPR_BITS-1:0]     spr;
    logic                    cal_done;
    logic [RUN_BITS-1:0]     remaining;
    logic [SPR_BITS-1:0]     nominal;
  } seq_state_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic                stepped;
    logic                busy;
    logic                calibrated;
    logic [SPR_BITS-1:0] measured_steps;
    logic                rejected;
  } seq_status_t;

  logic clk = 1'b0;
  logic rst_n;

  scs_in_if  in_ch();
  scs_out_if out_ch();
  scs_cfg_if cfg_ch();

  stepper_calibrating_sequencer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the block at acceptance, and the plan copy used to shape stimulus
  seq_state_t  shadow_seq;
  seq_state_t  plan_seq;
  scs_item_t   pending_commands[$];
  seq_status_t predicted_status[$];
  int unsigned words_queued    = 0;
  int unsigned results_checked = 0;
  int unsigned failures        = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;

  always #10 clk = ~clk;

  function automatic seq_state_t reset_state();
    seq_state_t s;
    s         = '0;
    s.mode    = MODE_IDLE;
    s.nominal = NOMINAL_SPR_RST;
    return s;
  endfunction

  task automatic half_step(inout seq_state_t s);
    s.coils = DRIVE_TABLE[{s.phase, 2'b00} +: 4];
    s.phase = s.phase + 3'd1;
  endtask

  task automatic counted_step(inout seq_state_t s);
    if (s.lap_count != LAP_MAX) s.lap_count = s.lap_count + 1'b1;
    half_step(s);
  endtask

  // one command word through the sequencer, status word out
  task automatic advance_sequencer(inout seq_state_t s, input scs_item_t it,
                                   output seq_status_t r);
    logic                was_busy;
    logic                level;
    logic [SUM_BITS-1:0] lap_sum;
    logic [SUM_BITS-1:0] lap_mean;
    logic [SPR_BITS-1:0] spr_used;
    begin
      was_busy = (s.mode != MODE_IDLE);
      level    = it.opto_level;
      r        = '0;
      case (it.command)
        CMD_TICK: begin
          if (s.mode == MODE_RUN) begin
            if (s.remaining != 0) begin
              half_step(s);
              r.stepped   = 1'b1;
              s.remaining = s.remaining - 1'b1;
            end
            if (s.remaining == 0) s.mode = MODE_IDLE;
          end else if (was_busy) begin
            // low level in the high part closes a lap
            if (s.mode == MODE_HIGH && !level) begin
              lap_sum     = SUM_BITS'(s.lap_total) + SUM_BITS'(s.lap_count);
              s.lap_total = (lap_sum > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX : lap_sum[COUNT_BITS+1:0];
              s.laps_done = s.laps_done + 2'd1;
              if (s.laps_done >= 2'(CAL_LAPS)) begin
                lap_mean   = (SUM_BITS'(s.lap_total) + SUM_BITS'(CAL_LAPS - 1))
                             / SUM_BITS'(CAL_LAPS);
                s.spr      = (lap_mean > SUM_BITS'(16'hFFFF)) ? 16'hFFFF
                                                              : lap_mean[SPR_BITS-1:0];
                s.cal_done = 1'b1;
                s.mode     = MODE_IDLE;
              end else begin
                s.mode = MODE_SEEK;
              end
            end
            // seeking: high steps uncounted, low starts a lap
            if (s.mode == MODE_SEEK) begin
              if (level) begin
                half_step(s);
                r.stepped = 1'b1;
              end else begin
                s.lap_count = '0;
                s.mode      = MODE_LOW;
              end
            end
            if (s.mode == MODE_LOW || s.mode == MODE_HIGH) begin
              if (level) s.mode = MODE_HIGH;
              counted_step(s);
              r.stepped = 1'b1;
            end
          end
        end
        CMD_RUN, CMD_CAL: begin
          if (was_busy) begin
            r.rejected = 1'b1;
          end else if (it.command == CMD_RUN) begin
            spr_used    = s.cal_done ? s.spr : s.nominal;
            s.remaining = (RUN_BITS'(it.eighths) * RUN_BITS'(spr_used)) >> 3;
            if (s.remaining != 0) s.mode = MODE_RUN;
          end else begin
            s.mode      = MODE_SEEK;
            s.lap_count = '0;
            s.lap_total = '0;
            s.laps_done = '0;
          end
        end
        default: ;
      endcase
      r.coils          = s.coils;
      r.busy           = (s.mode != MODE_IDLE);
      r.calibrated     = s.cal_done;
      r.measured_steps = s.spr;
    end
  endtask

  function automatic logic [EIGHTHS_BITS-1:0] any_eighths();
    return EIGHTHS_BITS'($urandom_range(1023));
  endfunction

  function automatic logic any_level();
    return 1'($urandom_range(1));
  endfunction

  task automatic queue_word(input logic [CMD_BITS-1:0] cmd,
                            input logic [EIGHTHS_BITS-1:0] eighths, input logic level);
    scs_item_t   it;
    seq_status_t unused;
    begin
      it.command    = cmd;
      it.eighths    = eighths;
      it.opto_level = level;
      advance_sequencer(plan_seq, it, unused);
      pending_commands.push_back(it);
      words_queued++;
    end
  endtask

  // a command that arrives while the block is at work
  task automatic queue_stray();
    int pick;
    begin
      pick = $urandom_range(2);
      queue_word((pick == 0) ? CMD_RUN : (pick == 1) ? CMD_CAL : CMD_IGNORED,
                 any_eighths(), any_level());
    end
  endtask

  // ticks until the run is spent, with the odd stray command
  task automatic finish_run();
    while (plan_seq.mode != MODE_IDLE) begin
      if ($urandom_range(99) < 4) queue_stray();
      else queue_word(CMD_TICK, any_eighths(), any_level());
    end
  endtask

  // run of a chosen or random length, kept to at most step_cap steps when random
  task automatic run_sequence(input int unsigned step_cap, input int forced);
    int unsigned spr_used;
    int unsigned e;
    begin
      spr_used = plan_seq.cal_done ? plan_seq.spr : plan_seq.nominal;
      if (forced >= 0) begin
        e = forced;
      end else begin
        e = $urandom_range(1023);
        while (e != 0 && e * spr_used / 8 > step_cap) e = e >> 1;
      end
      queue_word(CMD_RUN, EIGHTHS_BITS'(e), any_level());
      finish_run();
    end
  endtask

  // calibration driven by alternating opto segments, with glitches and strays
  task automatic cal_sequence(input int max_seg, input int long_low, input int noise_pct);
    logic level;
    int   seg_left;
    int   roll;
    begin
      queue_word(CMD_CAL, any_eighths(), any_level());
      level    = any_level();
      seg_left = $urandom_range(max_seg, 1);
      while (plan_seq.mode != MODE_IDLE) begin
        roll = $urandom_range(99);
        if (roll < noise_pct) begin
          queue_stray();
        end else begin
          queue_word(CMD_TICK, any_eighths(), (roll < 2 * noise_pct) ? ~level : level);
          seg_left--;
          if (seg_left == 0) begin
            level = ~level;
            if (!level && long_low != 0) begin
              seg_left = long_low;
              long_low = 0;
            end else begin
              seg_left = $urandom_range(max_seg, 1);
            end
          end
        end
      end
    end
  endtask

  // exact lap pattern: seek, then laps of 6, 2 and 2 steps, average rounded up to 4
  task automatic directed_calibration();
    logic [12:0] opto_pattern;
    begin
      opto_pattern = 13'b1100011101010;
      queue_word(CMD_CAL, 10'd0, 1'b0);
      queue_word(CMD_RUN, 10'd8, 1'b1);
      queue_word(CMD_CAL, 10'h3FF, 1'b1);
      queue_word(CMD_IGNORED, 10'h155, 1'b0);
      for (int i = 12; i >= 0; i--) queue_word(CMD_TICK, any_eighths(), opto_pattern[i]);
      run_sequence(0, 8);
      // a new calibration keeps the old figure until it completes
      cal_sequence(6, 0, 3);
    end
  endtask

  task automatic write_nominal(input logic [SPR_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid       <= 1'b0;
    shadow_seq.nominal = value;
    plan_seq.nominal   = value;
  endtask

  // word driver: takes from the pending queue, predicts on acceptance
  always @(posedge clk) begin : drive_words
    scs_item_t   taken;
    scs_item_t   next_word;
    seq_status_t status;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.command    = in_ch.command;
        taken.eighths    = in_ch.eighths;
        taken.opto_level = in_ch.opto_level;
        advance_sequencer(shadow_seq, taken, status);
        predicted_status.push_back(status);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word         = pending_commands.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.command    <= next_word.command;
          in_ch.eighths    <= next_word.eighths;
          in_ch.opto_level <= next_word.opto_level;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin : check_results
    seq_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_status.size() == 0) begin
        $error("result word with no prediction waiting");
        failures++;
      end else begin
        want = predicted_status.pop_front();
        results_checked++;
        if (out_ch.coils !== want.coils) begin
          $error("coils: expected %0h, got %0h", want.coils, out_ch.coils);
          failures++;
        end
        if (out_ch.stepped !== want.stepped) begin
          $error("stepped: expected %0b, got %0b", want.stepped, out_ch.stepped);
          failures++;
        end
        if (out_ch.busy_res !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, out_ch.busy_res);
          failures++;
        end
        if (out_ch.calibrated !== want.calibrated) begin
          $error("calibrated: expected %0b, got %0b", want.calibrated, out_ch.calibrated);
          failures++;
        end
        if (out_ch.measured_steps !== want.measured_steps) begin
          $error("measured_steps: expected %0d, got %0d", want.measured_steps,
                 out_ch.measured_steps);
          failures++;
        end
        if (out_ch.rejected !== want.rejected) begin
          $error("rejected: expected %0b, got %0b", want.rejected, out_ch.rejected);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned target;
    int          pick;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.eighths     = '0;
    in_ch.opto_level  = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    shadow_seq        = reset_state();
    plan_seq          = reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      // idling profile of this phase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (ph)
        1: write_nominal(16'd1);
        2: write_nominal(16'hFFFF);
        3: write_nominal(16'd3);
        4: write_nominal(SPR_BITS'($urandom_range(64, 4)));
        5: write_nominal(16'd4096);
        6: write_nominal(SPR_BITS'($urandom_range(65535, 1)));
        7: write_nominal(16'd2);
        default: ;
      endcase

      case (ph)
        0: begin
          // idle ticks hold the coils, zero-length run, busy rejections
          queue_word(CMD_TICK, 10'd0, 1'b0);
          queue_word(CMD_TICK, 10'h3FF, 1'b1);
          queue_word(CMD_IGNORED, 10'h3FF, 1'b1);
          queue_word(CMD_RUN, 10'd0, 1'b0);
          queue_word(CMD_RUN, 10'd1, 1'b0);
          queue_word(CMD_RUN, 10'h3FF, 1'b1);
          queue_word(CMD_CAL, 10'h2AA, 1'b0);
          queue_word(CMD_IGNORED, 10'd0, 1'b0);
          finish_run();
          queue_word(CMD_TICK, 10'h200, 1'b1);
        end
        1: run_sequence(0, 1023);
        4: begin
          directed_calibration();
          cal_sequence(12, 0, 0);
        end
        default: ;
      endcase

      target = words_queued + 100;
      while (words_queued < target) begin
        pick = $urandom_range(99);
        if (pick < 12) queue_word(CMD_TICK, any_eighths(), any_level());
        else if (pick < 20) queue_word(CMD_IGNORED, any_eighths(), any_level());
        else if (pick < 42 && ph >= 4)
          cal_sequence(($urandom_range(9) == 0) ? 40 : 12, 0, 3);
        else run_sequence(($urandom_range(9) == 0) ? 120 : 40, -1);
      end

      while (results_checked != words_queued) @(posedge clk);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
